>>> rtl/core/cslr_pkg.sv
// Package for the console scrollback line ring: sizes, request and key codes,
// ring index helpers and the structs passed between control and top level.
// No dependencies.
package cslr_pkg;

  localparam int NUM_LINES   = 512;
  localparam int LINE_LENGTH = 256;

  localparam int LINE_W = 9;
  localparam int COL_W  = 8;
  localparam int REQ_W  = 3;
  localparam int KEY_W  = 8;
  localparam int CHAR_ADDR_W = LINE_W + COL_W;
  localparam int CHAR_DEPTH  = NUM_LINES * LINE_LENGTH;
  localparam int META_W      = COL_W + 1;

  localparam logic [REQ_W-1:0] REQ_KEY         = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SCROLL_UP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SCROLL_DOWN = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MARK_PROMPT = 3'd4;

  localparam logic [KEY_W-1:0] KEY_NEWLINE   = 8'd10;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [KEY_W-1:0] PRINT_LOW     = 8'd32;
  localparam logic [KEY_W-1:0] PRINT_HIGH    = 8'd126;

  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(NUM_LINES - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(LINE_LENGTH - 1);

  // Index registers as seen on the result ports.
  typedef struct packed {
    logic [LINE_W-1:0] write_line;
    logic [COL_W-1:0]  write_column;
    logic [LINE_W-1:0] first_line;
    logic [LINE_W-1:0] view_top;
  } idx_t;

  // Memory writes issued for one accepted request.
  typedef struct packed {
    logic                   char_we;
    logic [CHAR_ADDR_W-1:0] char_addr;
    logic [KEY_W-1:0]       char_data;
    logic                   meta_we;
    logic [LINE_W-1:0]      meta_addr;
    logic [META_W-1:0]      meta_data;
  } mem_cmd_t;

  function automatic logic [LINE_W-1:0] ring_next(input logic [LINE_W-1:0] i);
    ring_next = (i == LAST_LINE) ? '0 : i + LINE_W'(1);
  endfunction

  function automatic logic [LINE_W-1:0] ring_prev(input logic [LINE_W-1:0] i);
    ring_prev = (i == '0) ? LAST_LINE : i - LINE_W'(1);
  endfunction

endpackage

>>> rtl/core/cslr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read. No dependencies.
module cslr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/cslr_ctrl.sv
// Request decode and index registers of the scrollback ring.
// Issues memory writes per request; depends on cslr_pkg.
module cslr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [cslr_pkg::REQ_W-1:0]  req_type,
  input  logic [cslr_pkg::KEY_W-1:0]  key_byte,
  input  logic                        jump_to_end,
  input  logic [cslr_pkg::LINE_W-1:0] read_line,
  output cslr_pkg::idx_t              idx,
  output cslr_pkg::mem_cmd_t          cmd,
  output logic                        status_next
);
  import cslr_pkg::*;

  idx_t idx_next;
  logic prompt_cur;
  logic prompt_cur_next;
  logic printable;

  assign printable = (key_byte >= PRINT_LOW) && (key_byte <= PRINT_HIGH);

  always_comb begin
    idx_next        = idx;
    prompt_cur_next = prompt_cur;
    status_next     = 1'b1;
    cmd.char_we     = 1'b0;
    cmd.char_addr   = {idx.write_line, idx.write_column};
    cmd.char_data   = key_byte;
    cmd.meta_we     = 1'b0;
    cmd.meta_addr   = idx.write_line;
    cmd.meta_data   = {prompt_cur, idx.write_column};
    case (req_type)
      REQ_KEY: begin
        if (key_byte == KEY_NEWLINE) begin
          idx_next.write_line = ring_next(idx.write_line);
          if (idx_next.write_line == idx.first_line) begin
            idx_next.first_line = ring_next(idx.first_line);
            // push the view along when it sits on the new oldest line
            if (idx_next.first_line == idx.view_top) begin
              idx_next.view_top = ring_next(idx.view_top);
            end
          end
          idx_next.write_column = '0;
          prompt_cur_next       = 1'b0;
          cmd.meta_we           = 1'b1;
          cmd.meta_addr         = idx_next.write_line;
          cmd.meta_data         = '0;
          status_next           = 1'b0;
        end else if (key_byte == KEY_BACKSPACE) begin
          if (idx.write_column != '0) begin
            idx_next.write_column = idx.write_column - COL_W'(1);
            cmd.meta_we           = 1'b1;
            cmd.meta_data         = {prompt_cur, idx_next.write_column};
          end
          status_next = 1'b0;
        end else if (printable) begin
          if (idx.write_column < LAST_COL) begin
            idx_next.write_column = idx.write_column + COL_W'(1);
            cmd.char_we           = 1'b1;
            cmd.meta_we           = 1'b1;
            cmd.meta_data         = {prompt_cur, idx_next.write_column};
            status_next           = 1'b0;
          end
        end
      end
      REQ_SCROLL_UP: begin
        if (idx.view_top != idx.first_line) begin
          idx_next.view_top = jump_to_end ? idx.first_line : ring_prev(idx.view_top);
          status_next       = 1'b0;
        end
      end
      REQ_SCROLL_DOWN: begin
        if (idx.view_top != idx.write_line) begin
          idx_next.view_top = jump_to_end ? idx.write_line : ring_next(idx.view_top);
          status_next       = 1'b0;
        end
      end
      REQ_READ: begin
        status_next = !({1'b0, read_line} < (LINE_W+1)'(NUM_LINES));
      end
      REQ_MARK_PROMPT: begin
        prompt_cur_next = 1'b1;
        cmd.meta_we     = 1'b1;
        cmd.meta_data   = {1'b1, idx.write_column};
        status_next     = 1'b0;
      end
      default: begin
        status_next = 1'b1;
      end
    endcase
    if (!accept) begin
      cmd.char_we = 1'b0;
      cmd.meta_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      prompt_cur <= 1'b0;
    end else if (accept) begin
      idx        <= idx_next;
      prompt_cur <= prompt_cur_next;
    end
  end

endmodule

>>> rtl/core/console_scrollback_line_ring_unit.sv
// Top level of the console scrollback line ring: character and line RAMs,
// clearing pass, read stage and output register.
// Depends on cslr_pkg, cslr_ram and cslr_ctrl.
//
//   channel   signals                                         direction
//   request   in_valid/in_ready, req_type, key_byte,           in
//             jump_to_end, read_line, read_column
//   result    out_valid/out_ready, status, read_char,          out
//             read_is_prompt, current_line, cursor_column,
//             oldest_line, top_line
//
// A taken request's result passes the read stage, then the output register: the
// registered RAM read happens at the accepting edge, the output register loads once free.
// One request per cycle is sustained while results are taken. After reset the
// line RAM is cleared one entry a cycle through its single write port, with
// in_ready low. A stalled result holds the read stage and then in_ready.
module console_scrollback_line_ring_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cslr_pkg::REQ_W-1:0]  req_type,
  input  logic [cslr_pkg::KEY_W-1:0]  key_byte,
  input  logic                        jump_to_end,
  input  logic [cslr_pkg::LINE_W-1:0] read_line,
  input  logic [cslr_pkg::COL_W-1:0]  read_column,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [cslr_pkg::KEY_W-1:0]  read_char,
  output logic                        read_is_prompt,
  output logic [cslr_pkg::LINE_W-1:0] current_line,
  output logic [cslr_pkg::COL_W-1:0]  cursor_column,
  output logic [cslr_pkg::LINE_W-1:0] oldest_line,
  output logic [cslr_pkg::LINE_W-1:0] top_line
);
  import cslr_pkg::*;

  idx_t     idx;
  mem_cmd_t cmd;
  logic     status_next;
  logic     accept;
  logic     load_out;
  logic     is_read;

  logic              clearing;
  logic [LINE_W-1:0] clear_addr;

  logic              pend;
  logic              pend_status;
  logic              pend_read;
  logic [COL_W-1:0]  pend_col;

  logic [KEY_W-1:0]  char_rdata;
  logic [META_W-1:0] meta_rdata;

  logic              meta_we;
  logic [LINE_W-1:0] meta_waddr;
  logic [META_W-1:0] meta_wdata;

  assign load_out = pend && (!out_valid || out_ready);
  assign in_ready = !clearing && (!pend || load_out);
  assign accept   = in_valid && in_ready;
  assign is_read  = (req_type == REQ_READ);

  cslr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (req_type),
    .key_byte    (key_byte),
    .jump_to_end (jump_to_end),
    .read_line   (read_line),
    .idx         (idx),
    .cmd         (cmd),
    .status_next (status_next)
  );

  cslr_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CHAR_DEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (cmd.char_we),
    .waddr (cmd.char_addr),
    .wdata (cmd.char_data),
    .re    (accept && is_read),
    .raddr ({read_line, read_column}),
    .rdata (char_rdata)
  );

  // clearing pass owns the line RAM write port until done
  assign meta_we    = clearing || cmd.meta_we;
  assign meta_waddr = clearing ? clear_addr : cmd.meta_addr;
  assign meta_wdata = clearing ? '0 : cmd.meta_data;

  cslr_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_LINES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (accept && is_read),
    .raddr (read_line),
    .rdata (meta_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + LINE_W'(1);
      if (clear_addr == LAST_LINE) begin
        clearing <= 1'b0;
      end
    end
  end

  // read stage: hold the request until the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (load_out) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_read   <= is_read && !status_next;
      pend_col    <= read_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // index registers already carry this request's update at load time
  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= pend_status;
      read_char      <= (pend_read && (pend_col < meta_rdata[COL_W-1:0])) ? char_rdata : '0;
      read_is_prompt <= pend_read && meta_rdata[META_W-1];
      current_line   <= idx.write_line;
      cursor_column  <= idx.write_column;
      oldest_line    <= idx.first_line;
      top_line       <= idx.view_top;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("request taken during clearing pass");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("read stage moved without a result");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_column <= LAST_COL))
    else $error("cursor column past line end");

  a_read_stage_blocks: assert property (@(posedge clk) disable iff (rst)
    (pend && !load_out) |-> !in_ready)
    else $error("request taken while read stage is held");

endmodule

>>> verif/console_scrollback_line_ring_unit_tb.sv
// Testbench for console_scrollback_line_ring_unit: directed and random request
// streams checked against an in-bench model of the scrollback ring.
// Depends on cslr_pkg and the console_scrollback_line_ring_unit RTL.
`timescale 1ns / 1ps

module console_scrollback_line_ring_unit_tb;
  import cslr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;

  typedef struct {
    bit              status;
    bit [KEY_W-1:0]  rchar;
    bit              rprompt;
    bit [LINE_W-1:0] wline;
    bit [COL_W-1:0]  wcol;
    bit [LINE_W-1:0] first;
    bit [LINE_W-1:0] top;
  } scrollback_view_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type;
  logic [KEY_W-1:0]  key_byte;
  logic              jump_to_end;
  logic [LINE_W-1:0] read_line;
  logic [COL_W-1:0]  read_column;
  logic              out_valid;
  logic              out_ready;
  logic              status;
  logic [KEY_W-1:0]  read_char;
  logic              read_is_prompt;
  logic [LINE_W-1:0] current_line;
  logic [COL_W-1:0]  cursor_column;
  logic [LINE_W-1:0] oldest_line;
  logic [LINE_W-1:0] top_line;

  // Model state of the ring.
  bit [KEY_W-1:0]  text_mem [NUM_LINES][LINE_LENGTH];
  bit [COL_W-1:0]  len_mem  [NUM_LINES];
  bit              mark_mem [NUM_LINES];
  bit [LINE_W-1:0] m_wline;
  bit [COL_W-1:0]  m_wcol;
  bit [LINE_W-1:0] m_first;
  bit [LINE_W-1:0] m_top;

  scrollback_view_t pending_views[$];
  scrollback_view_t seen_view;
  int mismatches;
  int cycles;
  bit steady;

  console_scrollback_line_ring_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .key_byte(key_byte), .jump_to_end(jump_to_end),
    .read_line(read_line), .read_column(read_column),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .read_char(read_char), .read_is_prompt(read_is_prompt),
    .current_line(current_line), .cursor_column(cursor_column),
    .oldest_line(oldest_line), .top_line(top_line)
  );

  always #6 clk = ~clk;

  function automatic bit [LINE_W-1:0] wrap_inc(input bit [LINE_W-1:0] i);
    return (int'(i) == NUM_LINES - 1) ? '0 : i + 1'b1;
  endfunction

  function automatic bit [LINE_W-1:0] wrap_dec(input bit [LINE_W-1:0] i);
    return (i == '0) ? LINE_W'(NUM_LINES - 1) : i - 1'b1;
  endfunction

  // Update the ring model for one accepted request and queue the view it yields.
  task automatic advance_scrollback(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                                    input logic jump, input logic [LINE_W-1:0] rline,
                                    input logic [COL_W-1:0] rcol);
    scrollback_view_t v;
    v.status  = 1'b1;
    v.rchar   = '0;
    v.rprompt = 1'b0;
    case (req)
      REQ_KEY: begin
        if (key == KEY_NEWLINE) begin
          m_wline = wrap_inc(m_wline);
          // Drop the oldest line on wrap; push the view only if it lands on it.
          if (m_wline == m_first) begin
            m_first = wrap_inc(m_first);
            if (m_first == m_top) m_top = wrap_inc(m_top);
          end
          m_wcol = '0;
          len_mem[m_wline] = '0;
          mark_mem[m_wline] = 1'b0;
          v.status = 1'b0;
        end else if (key == KEY_BACKSPACE) begin
          if (m_wcol != 0) begin
            m_wcol--;
            len_mem[m_wline] = m_wcol;
          end
          v.status = 1'b0;
        end else if (key >= PRINT_LOW && key <= PRINT_HIGH) begin
          if (m_wcol < LAST_COL) begin
            text_mem[m_wline][m_wcol] = key;
            m_wcol++;
            len_mem[m_wline] = m_wcol;
            v.status = 1'b0;
          end
        end
      end
      REQ_SCROLL_UP: begin
        if (m_top != m_first) begin
          m_top = jump ? m_first : wrap_dec(m_top);
          v.status = 1'b0;
        end
      end
      REQ_SCROLL_DOWN: begin
        if (m_top != m_wline) begin
          m_top = jump ? m_wline : wrap_inc(m_top);
          v.status = 1'b0;
        end
      end
      REQ_READ: begin
        if (int'(rline) < NUM_LINES) begin
          v.status  = 1'b0;
          v.rprompt = mark_mem[rline];
          if (rcol < len_mem[rline]) v.rchar = text_mem[rline][rcol];
        end
      end
      REQ_MARK_PROMPT: begin
        mark_mem[m_wline] = 1'b1;
        v.status = 1'b0;
      end
      default: ;
    endcase
    v.wline = m_wline;
    v.wcol  = m_wcol;
    v.first = m_first;
    v.top   = m_top;
    pending_views.push_back(v);
  endtask

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                              input logic jump, input logic [LINE_W-1:0] rline,
                              input logic [COL_W-1:0] rcol);
    int gap;
    gap = (!steady && $urandom_range(99) < 21) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    key_byte    <= key;
    jump_to_end <= jump;
    read_line   <= rline;
    read_column <= rcol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_scrollback(req, key, jump, rline, rcol);
  endtask

  task automatic send_key(input logic [KEY_W-1:0] k);
    send_request(REQ_KEY, k, 1'($urandom_range(1)), LINE_W'($urandom_range(NUM_LINES - 1)),
                 COL_W'($urandom_range(255)));
  endtask

  task automatic send_scroll(input logic [REQ_W-1:0] dir, input logic jump);
    send_request(dir, KEY_W'($urandom_range(255)), jump,
                 LINE_W'($urandom_range(NUM_LINES - 1)), COL_W'($urandom_range(255)));
  endtask

  task automatic send_read(input logic [LINE_W-1:0] rline, input logic [COL_W-1:0] rcol);
    send_request(REQ_READ, KEY_W'($urandom_range(255)), 1'($urandom_range(1)), rline, rcol);
  endtask

  task automatic send_mark();
    send_request(REQ_MARK_PROMPT, KEY_W'($urandom_range(255)), 1'($urandom_range(1)),
                 LINE_W'($urandom_range(NUM_LINES - 1)), COL_W'($urandom_range(255)));
  endtask

  task automatic send_printable();
    send_key(KEY_W'($urandom_range(PRINT_HIGH, PRINT_LOW)));
  endtask

  // Hold the request side until every result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] got);
    if (got !== exp) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_views.size() == 0) begin
          $display("%0t ns: result with no request outstanding, expected none, got line %0d",
                   $time, current_line);
          mismatches++;
        end else begin
          seen_view = pending_views.pop_front();
          check_field("status", seen_view.status, status);
          check_field("read_char", seen_view.rchar, read_char);
          check_field("read_is_prompt", seen_view.rprompt, read_is_prompt);
          check_field("current_line", seen_view.wline, current_line);
          check_field("cursor_column", seen_view.wcol, cursor_column);
          check_field("oldest_line", seen_view.first, oldest_line);
          check_field("top_line", seen_view.top, top_line);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  task automatic test_basic_edits();
    send_key(KEY_BACKSPACE);
    send_scroll(REQ_SCROLL_UP, 1'b0);
    send_scroll(REQ_SCROLL_DOWN, 1'b1);
    send_key(8'd0);
    send_key(8'd31);
    send_key(8'd127);
    send_key(8'd128);
    send_key(8'd255);
    send_key(PRINT_LOW);
    send_key(PRINT_HIGH);
    send_key(8'd65);
    send_read(9'd0, 8'd0);
    send_read(9'd0, 8'd2);
    send_read(9'd0, 8'd3);
    send_read(9'd0, LAST_COL);
    send_mark();
    send_read(9'd0, 8'd1);
    send_key(KEY_BACKSPACE);
    for (int i = 0; i < 3; i++)
      send_request(REQ_UNUSED_FIRST + REQ_W'(i), KEY_W'($urandom_range(255)),
                   1'($urandom_range(1)), LINE_W'($urandom_range(NUM_LINES - 1)),
                   COL_W'($urandom_range(255)));
    send_key(KEY_NEWLINE);
    send_read(9'd1, 8'd0);
    send_read(LAST_LINE, LAST_COL);
  endtask

  task automatic test_full_line();
    while (m_wcol < LAST_COL) send_printable();
    send_printable();
    send_key(PRINT_LOW);
    send_read(m_wline, LAST_COL - 1'b1);
    send_read(m_wline, LAST_COL);
    send_key(KEY_BACKSPACE);
    send_read(m_wline, LAST_COL - 1'b1);
    send_printable();
    send_key(KEY_NEWLINE);
  endtask

  task automatic test_scroll_limits();
    repeat (4) begin
      repeat ($urandom_range(3, 1)) send_printable();
      send_key(KEY_NEWLINE);
    end
    send_scroll(REQ_SCROLL_UP, 1'b0);
    send_scroll(REQ_SCROLL_UP, 1'b0);
    send_scroll(REQ_SCROLL_UP, 1'b1);
    send_scroll(REQ_SCROLL_UP, 1'b0);
    send_scroll(REQ_SCROLL_DOWN, 1'b0);
    send_scroll(REQ_SCROLL_DOWN, 1'b1);
    send_scroll(REQ_SCROLL_DOWN, 1'b0);
  endtask

  task automatic test_ring_wrap();
    if (m_top != m_first) send_scroll(REQ_SCROLL_UP, 1'b1);
    repeat (NUM_LINES + 6) begin
      repeat ($urandom_range(1)) send_printable();
      if ($urandom_range(15) == 0) send_mark();
      send_key(KEY_NEWLINE);
    end
    // Park the view just below the oldest line so the next wrap pushes it.
    repeat (6) begin
      send_scroll(REQ_SCROLL_UP, 1'b1);
      send_scroll(REQ_SCROLL_UP, 1'b0);
      send_scroll(REQ_SCROLL_DOWN, 1'b0);
      send_printable();
      send_key(KEY_NEWLINE);
      send_read(m_first, 8'd0);
      send_read(wrap_dec(m_wline), 8'd1);
    end
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [LINE_W-1:0] rl;
    logic [COL_W-1:0] rc;
    logic [KEY_W-1:0] k;
    for (int n = 0; n < 750; n++) begin
      steady = (n >= 250 && n < 550);
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_printable();
      end else if (pick < 58) begin
        send_key(KEY_NEWLINE);
      end else if (pick < 64) begin
        send_key(KEY_BACKSPACE);
      end else if (pick < 68) begin
        case ($urandom_range(2))
          0: begin
            k = KEY_W'($urandom_range(31));
            if (k == KEY_BACKSPACE || k == KEY_NEWLINE) k = '0;
          end
          1: k = 8'd127;
          default: k = KEY_W'($urandom_range(255, 128));
        endcase
        send_key(k);
      end else if (pick < 76) begin
        send_scroll(REQ_SCROLL_UP, $urandom_range(3) == 0);
      end else if (pick < 84) begin
        send_scroll(REQ_SCROLL_DOWN, $urandom_range(3) == 0);
      end else if (pick < 95) begin
        case ($urandom_range(3))
          0, 1: rl = m_wline;
          2: rl = m_wline - LINE_W'($urandom_range(4));
          default: rl = LINE_W'($urandom_range(NUM_LINES - 1));
        endcase
        if (len_mem[rl] != 0 && $urandom_range(1)) rc = COL_W'($urandom_range(len_mem[rl] - 1));
        else rc = COL_W'($urandom_range(255));
        send_read(rl, rc);
      end else if (pick < 98) begin
        send_mark();
      end else begin
        send_request(REQ_UNUSED_FIRST + REQ_W'($urandom_range(2)), KEY_W'($urandom_range(255)),
                     1'($urandom_range(1)), LINE_W'($urandom_range(NUM_LINES - 1)),
                     COL_W'($urandom_range(255)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** console_scrollback_line_ring_unit: FAILED **");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_KEY;
    key_byte = '0;
    jump_to_end = 1'b0;
    read_line = '0;
    read_column = '0;
    steady = 1'b0;
    mismatches = 0;
    cycles = 0;
    m_wline = '0;
    m_wcol = '0;
    m_first = '0;
    m_top = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basic_edits();
    test_full_line();
    test_scroll_limits();
    test_ring_wrap();
    test_random_traffic();
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("** console_scrollback_line_ring_unit: PASSED **");
    else
      $display("** console_scrollback_line_ring_unit: FAILED **");
    $finish;
  end

endmodule

>>> console_scrollback_line_ring_unit.f
rtl/core/cslr_pkg.sv
rtl/core/cslr_ram.sv
rtl/core/cslr_ctrl.sv
rtl/core/console_scrollback_line_ring_unit.sv
verif/console_scrollback_line_ring_unit_tb.sv
